// ===== src/gpe_pkg.sv =====
// Shared types, constants and address map for the GPIO port / EXTI block.
// Used by gpe_port_regs, gpe_exti and gpio_port_edge_interrupt_ctrl_core.
package gpe_pkg;

    localparam int GPE_PORTS = 4;

    // Beat kinds carried on s_axis_tuser
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Per-port register offsets (port p at p*0x400)
    localparam logic [9:0] OFF_MODE  = 10'h000;
    localparam logic [9:0] OFF_OTYPE = 10'h004;
    localparam logic [9:0] OFF_SPEED = 10'h008;
    localparam logic [9:0] OFF_PULL  = 10'h00C;
    localparam logic [9:0] OFF_IDR   = 10'h010;
    localparam logic [9:0] OFF_ODR   = 10'h014;
    localparam logic [9:0] OFF_BSRR  = 10'h018;
    localparam logic [9:0] OFF_AFRL  = 10'h020;
    localparam logic [9:0] OFF_AFRH  = 10'h024;

    // Pin mode code for general-purpose output
    localparam logic [1:0] MODE_OUTPUT = 2'b01;

    // EXTI register addresses
    localparam logic [15:0] ADDR_RTSR   = 16'h8000;
    localparam logic [15:0] ADDR_FTSR   = 16'h8004;
    localparam logic [15:0] ADDR_IMR    = 16'h8080;
    localparam logic [15:0] ADDR_PR     = 16'h8088;
    localparam logic [15:0] ADDR_SELECT = 16'h8408;
    localparam logic [15:0] ADDR_SEL_END = 16'h8418;

    // One decoded access, already qualified by the pipeline advance
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic        tick;
        logic [15:0] addr;
        logic [31:0] wdata;
    } gpe_acc_t;

endpackage

// ===== src/gpe_port_regs.sv =====
// Per-port GPIO registers: mode, type, speed, pull, output data, alt function,
// sampled input data. Depends on gpe_pkg.
module gpe_port_regs #(
    parameter int PORTS = gpe_pkg::GPE_PORTS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  gpe_pkg::gpe_acc_t acc,
    input  logic [63:0]      pins,
    output logic [31:0]      rdata,
    output logic [63:0]      pad_out,
    output logic [63:0]      pad_drive_mode
);
    import gpe_pkg::*;

    logic [31:0] mode_reg  [PORTS];
    logic [31:0] mode_next [PORTS];
    logic [15:0] otype_reg [PORTS];
    logic [15:0] otype_next[PORTS];
    logic [31:0] speed_reg [PORTS];
    logic [31:0] speed_next[PORTS];
    logic [31:0] pull_reg  [PORTS];
    logic [31:0] pull_next [PORTS];
    logic [15:0] odr_reg   [PORTS];
    logic [15:0] odr_next  [PORTS];
    logic [63:0] afr_reg   [PORTS];
    logic [63:0] afr_next  [PORTS];
    logic [15:0] idr_reg   [PORTS];
    logic [15:0] idr_next  [PORTS];

    logic [PORTS-1:0] hit;
    logic [9:0]       off;

    assign off = acc.addr[9:0];

    always_comb begin
        for (int p = 0; p < PORTS; p++) begin
            hit[p] = !acc.addr[15] && (acc.addr[14:10] == 5'(p));
        end
    end

    always_comb begin
        rdata          = '0;
        pad_out        = '0;
        pad_drive_mode = '0;
        for (int p = 0; p < PORTS; p++) begin
            mode_next[p]  = mode_reg[p];
            otype_next[p] = otype_reg[p];
            speed_next[p] = speed_reg[p];
            pull_next[p]  = pull_reg[p];
            odr_next[p]   = odr_reg[p];
            afr_next[p]   = afr_reg[p];
            idr_next[p]   = idr_reg[p];

            if (acc.wr && hit[p]) begin
                case (off)
                    OFF_MODE:  mode_next[p]  = acc.wdata;
                    OFF_OTYPE: otype_next[p] = acc.wdata[15:0];
                    OFF_SPEED: speed_next[p] = acc.wdata;
                    OFF_PULL:  pull_next[p]  = acc.wdata;
                    OFF_ODR:   odr_next[p]   = acc.wdata[15:0];
                    // set wins over reset
                    OFF_BSRR:  odr_next[p]   = (odr_reg[p] & ~acc.wdata[31:16])
                                               | acc.wdata[15:0];
                    OFF_AFRL:  afr_next[p]   = {afr_reg[p][63:32], acc.wdata};
                    OFF_AFRH:  afr_next[p]   = {acc.wdata, afr_reg[p][31:0]};
                    default: ;
                endcase
            end

            if (acc.tick) begin
                idr_next[p] = pins[16*p +: 16];
            end

            if (acc.rd && hit[p]) begin
                case (off)
                    OFF_MODE:  rdata = mode_reg[p];
                    OFF_OTYPE: rdata = {16'h0, otype_reg[p]};
                    OFF_SPEED: rdata = speed_reg[p];
                    OFF_PULL:  rdata = pull_reg[p];
                    OFF_IDR:   rdata = {16'h0, idr_reg[p]};
                    OFF_ODR:   rdata = {16'h0, odr_reg[p]};
                    OFF_AFRL:  rdata = afr_reg[p][31:0];
                    OFF_AFRH:  rdata = afr_reg[p][63:32];
                    default:   rdata = '0;
                endcase
            end

            // pad views show the state after this beat
            pad_out[16*p +: 16] = odr_next[p];
            for (int i = 0; i < 16; i++) begin
                pad_drive_mode[16*p + i] = (mode_next[p][2*i +: 2] == MODE_OUTPUT);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int p = 0; p < PORTS; p++) begin
            if (!aresetn) begin
                mode_reg[p]  <= '0;
                otype_reg[p] <= '0;
                speed_reg[p] <= '0;
                pull_reg[p]  <= '0;
                odr_reg[p]   <= '0;
                afr_reg[p]   <= '0;
                idr_reg[p]   <= '0;
            end else begin
                mode_reg[p]  <= mode_next[p];
                otype_reg[p] <= otype_next[p];
                speed_reg[p] <= speed_next[p];
                pull_reg[p]  <= pull_next[p];
                odr_reg[p]   <= odr_next[p];
                afr_reg[p]   <= afr_next[p];
                idr_reg[p]   <= idr_next[p];
            end
        end
    end

endmodule

// ===== src/gpe_exti.sv =====
// External interrupt controller: line-to-port select, edge detect, trigger
// enables, mask and pending bits, grouped interrupt vector. Depends on gpe_pkg.
module gpe_exti #(
    parameter int PORTS = gpe_pkg::GPE_PORTS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  gpe_pkg::gpe_acc_t acc,
    input  logic [63:0]      pins,
    output logic [31:0]      rdata,
    output logic [6:0]       irq_vec
);
    import gpe_pkg::*;

    logic [15:0] rise_reg,  rise_next;
    logic [15:0] fall_reg,  fall_next;
    logic [15:0] mask_reg,  mask_next;
    logic [15:0] pend_reg,  pend_next;
    logic [15:0] level_reg, level_next;
    logic [3:0]  sel_reg  [16];
    logic [3:0]  sel_next [16];

    logic [15:0] level;
    logic [15:0] sel_off;
    logic        sel_hit;
    logic [1:0]  grp;

    assign sel_off = acc.addr - ADDR_SELECT;
    assign sel_hit = (acc.addr >= ADDR_SELECT) && (acc.addr < ADDR_SEL_END)
                     && (acc.addr[1:0] == 2'b00);
    assign grp     = sel_off[3:2];

    // line level: pin of the selected port, zero when the port does not exist
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            level[i] = (sel_reg[i] < 4'(PORTS)) && pins[{sel_reg[i][1:0], 4'(i)}];
        end
    end

    always_comb begin
        rise_next  = rise_reg;
        fall_next  = fall_reg;
        mask_next  = mask_reg;
        pend_next  = pend_reg;
        level_next = level_reg;
        for (int i = 0; i < 16; i++) begin
            sel_next[i] = sel_reg[i];
        end
        rdata = '0;

        if (acc.wr) begin
            case (acc.addr)
                ADDR_RTSR: rise_next = acc.wdata[15:0];
                ADDR_FTSR: fall_next = acc.wdata[15:0];
                ADDR_IMR:  mask_next = acc.wdata[15:0];
                ADDR_PR:   pend_next = pend_reg & ~acc.wdata[15:0];
                default: begin
                    if (sel_hit) begin
                        for (int k = 0; k < 4; k++) begin
                            sel_next[{grp, 2'(k)}] = acc.wdata[4*k +: 4];
                        end
                    end
                end
            endcase
        end

        if (acc.tick) begin
            pend_next  = pend_reg | (((level & ~level_reg & rise_reg)
                                    | (~level & level_reg & fall_reg)) & mask_reg);
            level_next = level;
        end

        if (acc.rd) begin
            case (acc.addr)
                ADDR_RTSR: rdata = {16'h0, rise_reg};
                ADDR_FTSR: rdata = {16'h0, fall_reg};
                ADDR_IMR:  rdata = {16'h0, mask_reg};
                ADDR_PR:   rdata = {16'h0, pend_reg};
                default: begin
                    if (sel_hit) begin
                        for (int k = 0; k < 4; k++) begin
                            rdata[4*k +: 4] = sel_reg[{grp, 2'(k)}];
                        end
                    end
                end
            endcase
        end
    end

    assign irq_vec = {|pend_next[15:10], |pend_next[9:5], pend_next[4:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg  <= '0;
            fall_reg  <= '0;
            mask_reg  <= '0;
            pend_reg  <= '0;
            level_reg <= '0;
            for (int i = 0; i < 16; i++) begin
                sel_reg[i] <= '0;
            end
        end else begin
            rise_reg  <= rise_next;
            fall_reg  <= fall_next;
            mask_reg  <= mask_next;
            pend_reg  <= pend_next;
            level_reg <= level_next;
            for (int i = 0; i < 16; i++) begin
                sel_reg[i] <= sel_next[i];
            end
        end
    end

endmodule

// ===== src/gpio_port_edge_interrupt_ctrl_core.sv =====
// GPIO ports with external edge-interrupt controller. Each input beat is a bus
// read, a bus write or a pin sample tick (s_axis_tuser); each gives exactly one
// result beat carrying read data, the interrupt vector and the pad views after
// that beat. One beat per clock is sustained while the result side is ready; a beat
// is held in the input register and its result is presented from the result register.
// The result register frees the input side: a new beat is taken while a result
// waits, stalling only when both are full.
// Depends on gpe_pkg, gpe_port_regs and gpe_exti.
module gpio_port_edge_interrupt_ctrl_core #(
    parameter int PORTS = gpe_pkg::GPE_PORTS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // addr[15:0], wdata[47:16], pins_in[111:48]
    input  logic [1:0]   s_axis_tuser,  // func[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata   // rdata[31:0], irq_vec[38:32],
                                        // pad_out[102:39], pad_drive_mode[166:103]
);
    import gpe_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  in_func_reg;
    logic [15:0] in_addr_reg;
    logic [31:0] in_wdata_reg;
    logic [63:0] in_pins_reg;

    logic        out_valid_reg;
    logic [31:0] out_rdata_reg;
    logic [6:0]  out_irq_reg;
    logic [63:0] out_pad_reg;
    logic [63:0] out_drive_reg;

    logic        adv;
    gpe_acc_t    acc;
    logic [31:0] port_rdata;
    logic [31:0] exti_rdata;
    logic [63:0] pad_out;
    logic [63:0] pad_drive_mode;
    logic [6:0]  irq_vec;

    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;

    assign acc.rd    = adv && (in_func_reg == FUNC_READ);
    assign acc.wr    = adv && (in_func_reg == FUNC_WRITE);
    assign acc.tick  = adv && (in_func_reg == FUNC_TICK);
    assign acc.addr  = in_addr_reg;
    assign acc.wdata = in_wdata_reg;

    gpe_port_regs #(.PORTS(PORTS)) u_port_regs (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .acc            (acc),
        .pins           (in_pins_reg),
        .rdata          (port_rdata),
        .pad_out        (pad_out),
        .pad_drive_mode (pad_drive_mode)
    );

    gpe_exti #(.PORTS(PORTS)) u_exti (
        .aclk    (aclk),
        .aresetn (aresetn),
        .acc     (acc),
        .pins    (in_pins_reg),
        .rdata   (exti_rdata),
        .irq_vec (irq_vec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_func_reg  <= s_axis_tuser;
            in_addr_reg  <= s_axis_tdata[15:0];
            in_wdata_reg <= s_axis_tdata[47:16];
            in_pins_reg  <= s_axis_tdata[111:48];
        end
        if (adv) begin
            out_rdata_reg <= port_rdata | exti_rdata;
            out_irq_reg   <= irq_vec;
            out_pad_reg   <= pad_out;
            out_drive_reg <= pad_drive_mode;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_drive_reg, out_pad_reg, out_irq_reg, out_rdata_reg};

    // an advancing beat always lands in the result register
    a_adv_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> out_valid_reg)
        else $error("advanced beat did not produce a result");

    // an empty result register never stalls the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // only reads return data
    a_rdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && (in_func_reg != FUNC_READ)) |=> (out_rdata_reg == 32'h0))
        else $error("non-read beat returned read data");

endmodule

// ===== bench/tb_gpio_port_edge_interrupt_ctrl_core.sv =====
// Self-checking bench for gpio_port_edge_interrupt_ctrl_core: register map, pin ticks,
// EXTI edge capture and pad views, checked beat by beat against a local register model.
// Depends on gpe_pkg and the core RTL.
module tb_gpio_port_edge_interrupt_ctrl_core;
    timeunit 1ns;
    timeprecision 1ps;
    import gpe_pkg::*;

    localparam int NPORT = GPE_PORTS;
    localparam logic [1:0] FUNC_NOP = 2'd3;       // undefined kind, state untouched
    localparam logic [9:0] OFF_LOCK = 10'h01C;    // not implemented, reads as zero
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [63:0] drive;
        logic [63:0] pad_out;
        logic [6:0]  irq;
        logic [31:0] rdata;
    } gpio_view_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;   // addr[15:0], wdata[47:16], pins_in[111:48]
    logic [1:0]   s_axis_tuser = '0;   // func[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;        // rdata[31:0], irq_vec[38:32],
                                       // pad_out[102:39], pad_drive_mode[166:103]

    // register image of the block
    logic [31:0] mode_q  [NPORT];
    logic [15:0] otype_q [NPORT];
    logic [31:0] speed_q [NPORT];
    logic [31:0] pull_q  [NPORT];
    logic [15:0] odr_q   [NPORT];
    logic [63:0] afr_q   [NPORT];
    logic [15:0] rtsr_q, ftsr_q, imr_q, pend_q, lvl_q;
    logic [3:0]  line_sel_q [16];
    logic [63:0] pins_q;

    gpio_view_t exp_views [$];
    int  mismatch_cnt = 0;
    bit  src_idle_on = 1'b0;
    bit  sink_idle_on = 1'b0;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    gpio_port_edge_interrupt_ctrl_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- register model ----------------

    function automatic void clear_regs();
        for (int p = 0; p < NPORT; p++) begin
            mode_q[p] = '0; otype_q[p] = '0; speed_q[p] = '0;
            pull_q[p] = '0; odr_q[p] = '0; afr_q[p] = '0;
        end
        for (int i = 0; i < 16; i++) line_sel_q[i] = '0;
        rtsr_q = '0; ftsr_q = '0; imr_q = '0; pend_q = '0; lvl_q = '0;
        pins_q = '0;
    endfunction

    function automatic logic [31:0] bus_rd(input logic [15:0] a);
        int p;
        int base;
        logic [31:0] v;
        p = int'(a[14:10]);
        v = '0;
        if (!a[15]) begin
            if (p < NPORT) begin
                case (a[9:0])
                    OFF_MODE:  v = mode_q[p];
                    OFF_OTYPE: v = {16'h0, otype_q[p]};
                    OFF_SPEED: v = speed_q[p];
                    OFF_PULL:  v = pull_q[p];
                    OFF_IDR:   v = {16'h0, pins_q[p*16 +: 16]};
                    OFF_ODR:   v = {16'h0, odr_q[p]};
                    OFF_AFRL:  v = afr_q[p][31:0];
                    OFF_AFRH:  v = afr_q[p][63:32];
                    default:   v = '0;
                endcase
            end
        end else if (a == ADDR_RTSR) v = {16'h0, rtsr_q};
        else if (a == ADDR_FTSR) v = {16'h0, ftsr_q};
        else if (a == ADDR_IMR)  v = {16'h0, imr_q};
        else if (a == ADDR_PR)   v = {16'h0, pend_q};
        else if (a >= ADDR_SELECT && a < ADDR_SEL_END && a[1:0] == 2'b00) begin
            base = int'((a - ADDR_SELECT) >> 2) * 4;
            for (int k = 0; k < 4; k++) v[4*k +: 4] = line_sel_q[base + k];
        end
        return v;
    endfunction

    function automatic void bus_wr(input logic [15:0] a, input logic [31:0] d);
        int p;
        int base;
        p = int'(a[14:10]);
        if (!a[15]) begin
            if (p < NPORT) begin
                case (a[9:0])
                    OFF_MODE:  mode_q[p] = d;
                    OFF_OTYPE: otype_q[p] = d[15:0];
                    OFF_SPEED: speed_q[p] = d;
                    OFF_PULL:  pull_q[p] = d;
                    OFF_ODR:   odr_q[p] = d[15:0];
                    OFF_BSRR:  odr_q[p] = (odr_q[p] & ~d[31:16]) | d[15:0];
                    OFF_AFRL:  afr_q[p][31:0] = d;
                    OFF_AFRH:  afr_q[p][63:32] = d;
                    default:   ;
                endcase
            end
        end else if (a == ADDR_RTSR) rtsr_q = d[15:0];
        else if (a == ADDR_FTSR) ftsr_q = d[15:0];
        else if (a == ADDR_IMR)  imr_q = d[15:0];
        else if (a == ADDR_PR)   pend_q = pend_q & ~d[15:0];
        else if (a >= ADDR_SELECT && a < ADDR_SEL_END && a[1:0] == 2'b00) begin
            base = int'((a - ADDR_SELECT) >> 2) * 4;
            for (int k = 0; k < 4; k++) line_sel_q[base + k] = d[4*k +: 4];
        end
    endfunction

    function automatic void pin_tick(input logic [63:0] pins);
        logic [15:0] lvl;
        logic [15:0] rise;
        logic [15:0] fall;
        int p;
        lvl = '0;
        pins_q = pins;
        for (int i = 0; i < 16; i++) begin
            p = int'(line_sel_q[i]);
            if (p < NPORT) lvl[i] = pins[p*16 + i];
        end
        rise = lvl & ~lvl_q;
        fall = ~lvl & lvl_q;
        pend_q = pend_q | (((rise & rtsr_q) | (fall & ftsr_q)) & imr_q);
        lvl_q = lvl;
    endfunction

    function automatic gpio_view_t predict_view(input logic [1:0] fn, input logic [15:0] a,
                                                input logic [31:0] d, input logic [63:0] pins);
        gpio_view_t v;
        v = '0;
        case (fn)
            FUNC_READ:  v.rdata = bus_rd(a);
            FUNC_WRITE: bus_wr(a, d);
            FUNC_TICK:  pin_tick(pins);
            default:    ;
        endcase
        v.irq = {|pend_q[15:10], |pend_q[9:5], pend_q[4:0]};
        for (int p = 0; p < NPORT; p++) begin
            v.pad_out[p*16 +: 16] = odr_q[p];
            for (int i = 0; i < 16; i++)
                v.drive[p*16 + i] = (mode_q[p][2*i +: 2] == MODE_OUTPUT);
        end
        return v;
    endfunction

    // ---------------- result checking ----------------

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge aclk) begin
        gpio_view_t got;
        gpio_view_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[166:0];
            if (exp_views.size() == 0) begin
                flag_mismatch("result beat with nothing pending", '0, 64'(got.rdata));
            end else begin
                want = exp_views.pop_front();
                if (got.rdata !== want.rdata)
                    flag_mismatch("rdata", 64'(want.rdata), 64'(got.rdata));
                if (got.irq !== want.irq)
                    flag_mismatch("irq_vec", 64'(want.irq), 64'(got.irq));
                if (got.pad_out !== want.pad_out)
                    flag_mismatch("pad_out", want.pad_out, got.pad_out);
                if (got.drive !== want.drive)
                    flag_mismatch("pad_drive_mode", want.drive, got.drive);
            end
        end
    end

    // result side ready: random stall bursts plus an on-demand long hold-off
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------- stimulus ----------------

    // leaves tvalid high on return so a following beat goes out back to back
    task automatic send_beat(input logic [1:0] fn, input logic [15:0] a,
                             input logic [31:0] d, input logic [63:0] pins);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {pins, d, a};
        do @(posedge aclk); while (!s_axis_tready);
        exp_views.push_back(predict_view(fn, a, d, pins));
    endtask

    task automatic src_gap(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (exp_views.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] port_addr(input int p, input logic [9:0] off);
        return {p[5:0], off};
    endfunction

    function automatic logic [9:0] port_off(input int k);
        case (k)
            0: return OFF_MODE;
            1: return OFF_OTYPE;
            2: return OFF_SPEED;
            3: return OFF_PULL;
            4: return OFF_IDR;
            5: return OFF_ODR;
            6: return OFF_BSRR;
            7: return OFF_AFRL;
            8: return OFF_AFRH;
            default: return OFF_LOCK;
        endcase
    endfunction

    function automatic logic [15:0] exti_addr(input int k);
        case (k)
            0: return ADDR_RTSR;
            1: return ADDR_FTSR;
            2: return ADDR_IMR;
            3: return ADDR_PR;
            default: return ADDR_SELECT + 16'(4 * (k - 4));
        endcase
    endfunction

    // mostly real ports, now and then a select beyond them
    function automatic logic [31:0] sel_word();
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 4; k++)
            w[4*k +: 4] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(NPORT, 15))
                                                       : 4'($urandom_range(0, NPORT - 1));
        w[31:16] = 16'($urandom);
        return w;
    endfunction

    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                return port_addr($urandom_range(0, NPORT), port_off($urandom_range(0, 9)));
            6, 7:    return exti_addr($urandom_range(0, 7));
            8:       return 16'($urandom);
            default: return 16'h8000 + 16'($urandom_range(0, 16'h420));
        endcase
    endfunction

    task automatic rand_beat();
        logic [1:0]  fn;
        logic [15:0] a;
        logic [31:0] d;
        logic [63:0] pins;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) fn = FUNC_TICK;
        else if (pick < 65) fn = FUNC_READ;
        else if (pick < 95) fn = FUNC_WRITE;
        else fn = FUNC_NOP;
        a = pick_addr();
        d = $urandom;
        if (a >= ADDR_SELECT && a < ADDR_SEL_END) d = sel_word();
        // single-pin toggles give isolated edges, full random gives bursts of them
        if ($urandom_range(0, 1) == 0) pins = {$urandom, $urandom};
        else pins = pins_q ^ (64'd1 << $urandom_range(0, 63));
        if (src_idle_on && $urandom_range(0, 9) == 0) src_gap($urandom_range(1, 19));
        send_beat(fn, a, d, pins);
    endtask

    task automatic exti_setup();
        send_beat(FUNC_WRITE, ADDR_IMR, $urandom_range(0, 3) == 0 ? $urandom : 32'hFFFF, '0);
        send_beat(FUNC_WRITE, ADDR_RTSR, $urandom, '0);
        send_beat(FUNC_WRITE, ADDR_FTSR, $urandom, '0);
        for (int k = 4; k < 8; k++) send_beat(FUNC_WRITE, exti_addr(k), sel_word(), '0);
    endtask

    // ---------------- tests ----------------

    task automatic test_register_map();
        send_beat(FUNC_READ,  port_addr(0, OFF_MODE), 32'h0, 64'h0);
        send_beat(FUNC_WRITE, port_addr(0, OFF_MODE), 32'h5555_5555, 64'h0);
        send_beat(FUNC_WRITE, port_addr(3, OFF_MODE), 32'hFFFF_FFFF, 64'h0);
        send_beat(FUNC_WRITE, port_addr(1, OFF_OTYPE), 32'hFFFF_FFFF, 64'h0);
        send_beat(FUNC_WRITE, port_addr(2, OFF_SPEED), 32'hFFFF_FFFF, 64'h0);
        send_beat(FUNC_WRITE, port_addr(3, OFF_PULL), 32'hA5A5_5A5A, 64'h0);
        send_beat(FUNC_WRITE, port_addr(1, OFF_ODR), 32'hFFFF_FFFF, 64'h0);
        // set and reset of the same bits: set wins
        send_beat(FUNC_WRITE, port_addr(1, OFF_BSRR), 32'h00FF_0F0F, 64'h0);
        send_beat(FUNC_READ,  port_addr(1, OFF_BSRR), 32'h0, 64'h0);
        send_beat(FUNC_READ,  port_addr(1, OFF_ODR), 32'h0, 64'h0);
        send_beat(FUNC_WRITE, port_addr(2, OFF_AFRL), 32'hFFFF_FFFF, 64'h0);
        send_beat(FUNC_WRITE, port_addr(2, OFF_AFRH), 32'h8000_0001, 64'h0);
        send_beat(FUNC_READ,  port_addr(2, OFF_AFRH), 32'h0, 64'h0);
        send_beat(FUNC_WRITE, port_addr(0, OFF_IDR), 32'hFFFF_FFFF, 64'h0);
        send_beat(FUNC_TICK,  16'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(FUNC_READ,  port_addr(0, OFF_IDR), 32'h0, 64'h0);
        // unmapped: port past the last, unaligned, lock register, top of space
        send_beat(FUNC_WRITE, port_addr(NPORT, OFF_MODE), 32'hFFFF_FFFF, 64'h0);
        send_beat(FUNC_READ,  16'h0002, 32'h0, 64'h0);
        send_beat(FUNC_READ,  port_addr(0, OFF_LOCK), 32'h0, 64'h0);
        send_beat(FUNC_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(FUNC_NOP,   16'hFFFF, 32'hFFFF_FFFF, 64'h0);
        // line 3 selects a missing port and must stay low
        send_beat(FUNC_WRITE, ADDR_SELECT, 32'h0000_F310, 64'h0);
        send_beat(FUNC_WRITE, ADDR_IMR, 32'hFFFF_FFFF, 64'h0);
        send_beat(FUNC_WRITE, ADDR_RTSR, 32'hFFFF_FFFF, 64'h0);
        send_beat(FUNC_WRITE, ADDR_FTSR, 32'h0000_FFFF, 64'h0);
        send_beat(FUNC_TICK,  16'h0, 32'h0, 64'h0);
        send_beat(FUNC_READ,  ADDR_PR, 32'h0, 64'h0);
        send_beat(FUNC_WRITE, ADDR_PR, 32'hFFFF_FFFF, 64'h0);
        send_beat(FUNC_READ,  ADDR_SELECT, 32'h0, 64'h0);
        drain_results();
    endtask

    task automatic test_random_traffic(input int n);
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) exti_setup();
            rand_beat();
        end
        drain_results();
    endtask

    task automatic test_backpressure(input int n);
        src_idle_on = 1'b0;
        hold_reqs++;
        for (int i = 0; i < n; i++) rand_beat();
        drain_results();
    endtask

    task automatic test_steady_stream(input int n);
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        exti_setup();
        for (int i = 0; i < n; i++) rand_beat();
        drain_results();
    endtask

    initial begin
        clear_regs();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_map();
        test_random_traffic(520);
        test_backpressure(80);
        test_random_traffic(60);
        test_steady_stream(120);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        mismatch_cnt += exp_views.size();
        if (mismatch_cnt == 0) begin
            $display("** gpio_port_edge_interrupt_ctrl_core: PASSED **");
        end else begin
            $display("** gpio_port_edge_interrupt_ctrl_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** gpio_port_edge_interrupt_ctrl_core: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
src/gpe_pkg.sv
src/gpe_port_regs.sv
src/gpe_exti.sv
src/gpio_port_edge_interrupt_ctrl_core.sv
bench/tb_gpio_port_edge_interrupt_ctrl_core.sv
